FILE: rtl/dftd_pkg.sv
// ----------------------------------------------------------------------------
// dftd_pkg
// Shared types, constants and the quarter-wave cosine table for the direct
// DFT block.
// ----------------------------------------------------------------------------
`default_nettype none

package dftd_pkg;

   // Default sizes, handed to the top level as parameter defaults
   localparam int DEF_MAX_POINTS   = 64;
   localparam int DEF_SAMPLE_BITS  = 16;
   localparam int DEF_TWIDDLE_BITS = 16;

   // Result field
   localparam int OUT_W   = 24;
   localparam int OUT_MAX = 8388607;
   localparam int OUT_MIN = -8388608;

   // Configuration port
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 3;
   localparam int LOG2_W     = 3;
   localparam logic [CSR_IDX_W-1:0] REG_LOG2_POINTS  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_INVERSE_MODE = 1'b1;
   localparam logic [LOG2_W-1:0]    LOG2_RESET       = 3'd6;
   localparam int LOG2_LIMIT = 6;

   // Phase is kept in 64ths of a turn
   localparam int PHASE_W  = 6;
   localparam int ROM_TURN = 64;

   // Quarter-wave cosine table, Q1.23
   localparam int ROM_W = 24;
   localparam logic [ROM_W-1:0] COS_ROM [0:16] = '{
      24'd8388608, 24'd8348215, 24'd8227423, 24'd8027397, 24'd7750063,
      24'd7398092, 24'd6974873, 24'd6484482, 24'd5931642, 24'd5321677,
      24'd4660461, 24'd3954362, 24'd3210181, 24'd2435084, 24'd1636536,
      24'd822227,  24'd0
   };

   // One finished frame waiting for the transform engine
   typedef struct packed {
      logic              bank;
      logic [LOG2_W-1:0] l;
      logic              inv;
   } job_type;

   // Table entry reduced to tb bits, rounded half up and capped
   function automatic logic [ROM_W:0] rom_mag(input logic [4:0] r, input int tb);
      logic [ROM_W:0] v;
      logic [ROM_W:0] cap;
      int             sh;
      v   = (r > 5'd16) ? '0 : {1'b0, COS_ROM[r]};
      sh  = ROM_W - tb;
      cap = (ROM_W+1)'((1 << (tb - 1)) - 1);
      if (sh > 0) begin
         v = (v + (ROM_W+1)'(1 << (sh - 1))) >> sh;
      end
      if (v > cap) begin
         v = cap;
      end
      return v;
   endfunction

   // Cosine of a phase by quadrant symmetry
   function automatic logic signed [ROM_W:0] cos_at(input logic [PHASE_W-1:0] p,
                                                    input int tb);
      logic [1:0]     q;
      logic [3:0]     r;
      logic [ROM_W:0] m;
      q = p[5:4];
      r = p[3:0];
      m = q[0] ? rom_mag(5'd16 - {1'b0, r}, tb) : rom_mag({1'b0, r}, tb);
      return (q == 2'd1 || q == 2'd2) ? -$signed(m) : $signed(m);
   endfunction

   // Sine is cosine three quarters of a turn on
   function automatic logic signed [ROM_W:0] sin_at(input logic [PHASE_W-1:0] p,
                                                    input int tb);
      return cos_at(p + PHASE_W'(48), tb);
   endfunction

endpackage

`default_nettype wire

FILE: rtl/dftd_front.sv
// ----------------------------------------------------------------------------
// dftd_front
// Takes sample beats and configuration writes, fills one of two sample
// banks and hands each full frame on as a job.
// ----------------------------------------------------------------------------
`default_nettype none

module dftd_front
   import dftd_pkg::*;
#(
   parameter int MAX_POINTS  = DEF_MAX_POINTS,
   parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0]          csr_index,
   input  wire logic [CSR_DATA_W-1:0]         csr_wdata,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic signed [SAMPLE_BITS-1:0] req_sample_re,
   input  wire logic signed [SAMPLE_BITS-1:0] req_sample_im,
   output logic                               job_push,
   output job_type                            job_out,
   input  wire logic                          bank_release,
   input  wire logic                          rd_en,
   input  wire logic [$clog2(MAX_POINTS):0]   rd_addr,
   output logic signed [SAMPLE_BITS-1:0]      rd_re,
   output logic signed [SAMPLE_BITS-1:0]      rd_im
);

   localparam int AW      = $clog2(MAX_POINTS);
   localparam int MEM_D   = 2 ** (AW + 1);
   localparam int FLOOR_L = $clog2(MAX_POINTS + 1) - 1;
   localparam int LOG_CAP = (FLOOR_L > LOG2_LIMIT) ? LOG2_LIMIT : FLOOR_L;

   logic [LOG2_W-1:0] log2_ff, log2_in;
   logic              inv_ff, inv_in;
   logic [AW:0]       fill_ff, fill_in;
   logic              wb_ff, wb_in;
   logic [1:0]        busy_ff, busy_in;

   logic signed [SAMPLE_BITS-1:0] re_mem [MEM_D];
   logic signed [SAMPLE_BITS-1:0] im_mem [MEM_D];
   logic signed [SAMPLE_BITS-1:0] rd_re_ff, rd_im_ff;

   logic              accept;
   logic [LOG2_W-1:0] l_act;
   logic [AW:0]       n_pts;
   logic [AW:0]       idx;
   logic [AW:0]       fill_next;
   logic              frame_done;

   // Both banks owned by the engine: hold off new samples
   assign req_stall = (busy_ff == 2'd2);
   assign accept    = req_valid && !req_stall;

   // Clamp the programmed length to what the store can hold
   always_comb begin
      if (log2_ff < LOG2_W'(1)) begin
         l_act = LOG2_W'(1);
      end else if (log2_ff > LOG2_W'(LOG_CAP)) begin
         l_act = LOG2_W'(LOG_CAP);
      end else begin
         l_act = log2_ff;
      end
   end

   assign n_pts      = (AW+1)'(1) << l_act;
   assign idx        = (fill_ff >= n_pts) ? '0 : fill_ff;
   assign fill_next  = idx + (AW+1)'(1);
   assign frame_done = (fill_next == n_pts);
   assign job_push   = accept && frame_done;

   assign job_out.bank = wb_ff;
   assign job_out.l    = l_act;
   assign job_out.inv  = inv_ff;

   // Advance fill position, swap banks on a full frame, apply writes
   always_comb begin
      log2_in = log2_ff;
      inv_in  = inv_ff;
      fill_in = fill_ff;
      wb_in   = wb_ff;
      if (accept) begin
         if (frame_done) begin
            fill_in = '0;
            wb_in   = !wb_ff;
         end else begin
            fill_in = fill_next;
         end
      end
      if (csr_write_enable) begin
         case (csr_index)
            REG_LOG2_POINTS: begin
               log2_in = csr_wdata[LOG2_W-1:0];
               fill_in = '0;
            end
            REG_INVERSE_MODE: begin
               inv_in = csr_wdata[0];
            end
            default: begin
               log2_in = log2_ff;
            end
         endcase
      end
   end

   // Count banks held by queued or running jobs
   always_comb begin
      case ({job_push, bank_release})
         2'b10:   busy_in = busy_ff + 2'd1;
         2'b01:   busy_in = busy_ff - 2'd1;
         default: busy_in = busy_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         log2_ff <= LOG2_RESET;
         inv_ff  <= 1'b0;
         fill_ff <= '0;
         wb_ff   <= 1'b0;
         busy_ff <= '0;
      end else begin
         log2_ff <= log2_in;
         inv_ff  <= inv_in;
         fill_ff <= fill_in;
         wb_ff   <= wb_in;
         busy_ff <= busy_in;
      end
   end

   // Sample banks: write on each accepted beat, registered read for the engine
   always_ff @(posedge clock) begin
      if (accept) begin
         re_mem[{wb_ff, idx[AW-1:0]}] <= req_sample_re;
         im_mem[{wb_ff, idx[AW-1:0]}] <= req_sample_im;
      end
      if (rd_en) begin
         rd_re_ff <= re_mem[rd_addr];
         rd_im_ff <= im_mem[rd_addr];
      end
   end

   assign rd_re = rd_re_ff;
   assign rd_im = rd_im_ff;

endmodule

`default_nettype wire

FILE: rtl/dftd_job_fifo.sv
// ----------------------------------------------------------------------------
// dftd_job_fifo
// Two-entry queue of finished frames between the sample front end and the
// transform engine.
// ----------------------------------------------------------------------------
`default_nettype none

module dftd_job_fifo
   import dftd_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire job_type push_job,
   input  wire logic    pop,
   output logic         job_valid,
   output job_type      job_head
);

   job_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign job_valid = (count_ff != 2'd0);
   assign job_head  = slot_ff[rd_ptr_ff];

   // Move pointers and occupancy
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? !rd_ptr_ff : rd_ptr_ff;
      case ({push, pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/dftd_back.sv
// ----------------------------------------------------------------------------
// dftd_back
// Transform engine: steps over bins and samples, one complex multiply-accumulate
// per cycle unless stalled; rounds, scales in inverse mode and saturates each bin.
// ----------------------------------------------------------------------------
`default_nettype none

module dftd_back
   import dftd_pkg::*;
#(
   parameter int MAX_POINTS   = DEF_MAX_POINTS,
   parameter int SAMPLE_BITS  = DEF_SAMPLE_BITS,
   parameter int TWIDDLE_BITS = DEF_TWIDDLE_BITS
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          job_valid,
   input  wire job_type                       job_head,
   output logic                               job_pop,
   output logic                               bank_release,
   output logic                               rd_en,
   output logic [$clog2(MAX_POINTS):0]        rd_addr,
   input  wire logic signed [SAMPLE_BITS-1:0] rd_re,
   input  wire logic signed [SAMPLE_BITS-1:0] rd_im,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic signed [OUT_W-1:0]            rsp_bin_re,
   output logic signed [OUT_W-1:0]            rsp_bin_im,
   output logic                               rsp_bin_last
);

   localparam int AW    = $clog2(MAX_POINTS);
   localparam int TB    = TWIDDLE_BITS;
   localparam int PW    = SAMPLE_BITS + TWIDDLE_BITS;
   localparam int TW    = PW + 1;
   localparam int ACC_W = (PW + AW + 2 > OUT_W) ? PW + AW + 2 : OUT_W + 1;
   localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) << (TWIDDLE_BITS - 2);

   typedef enum logic [1:0] {
      SEQ_IDLE = 2'b01,
      SEQ_RUN  = 2'b10
   } seq_state_type;

   typedef struct packed {
      logic              valid;
      logic              first;
      logic              last_term;
      logic              last_bin;
      logic              inv;
      logic [LOG2_W-1:0] l;
   } flags_type;

   // Divide by 2^l, truncating toward zero
   function automatic logic signed [ACC_W-1:0] trunc_shift(
      input logic signed [ACC_W-1:0] v, input logic [LOG2_W-1:0] l);
      logic             neg;
      logic [ACC_W-1:0] mag;
      logic [ACC_W-1:0] sh;
      neg = v[ACC_W-1];
      mag = neg ? ACC_W'(-v) : ACC_W'(v);
      sh  = mag >> l;
      return neg ? -$signed(sh) : $signed(sh);
   endfunction

   // Clip to the result field
   function automatic logic signed [OUT_W-1:0] saturate(
      input logic signed [ACC_W-1:0] v);
      if (v > ACC_W'(OUT_MAX)) begin
         return OUT_W'(OUT_MAX);
      end else if (v < ACC_W'(OUT_MIN)) begin
         return OUT_W'(OUT_MIN);
      end
      return v[OUT_W-1:0];
   endfunction

   // Sequencer
   seq_state_type     state_ff, state_in;
   logic              bank_ff, bank_in;
   logic [LOG2_W-1:0] l_ff, l_in;
   logic              inv_ff, inv_in;
   logic [AW-1:0]     nm1_ff, nm1_in;
   logic [PHASE_W-1:0] step_ff, step_in;
   logic [AW-1:0]     j_ff, j_in;
   logic [AW-1:0]     k_ff, k_in;
   logic [PHASE_W-1:0] ph_ff, ph_in;
   logic [PHASE_W-1:0] kstep_ff, kstep_in;
   logic              issue;
   logic              advance;

   // Datapath stages
   flags_type               f1_ff, f1_in, f2_ff, f3_ff, f4_ff, f4_in, f5_ff, f6_ff;
   logic signed [TB-1:0]    c1_ff, c1_in, sn1_ff, sn1_in;
   logic signed [ROM_W:0]   cos_w, sin_w;
   logic signed [PW-1:0]    pac2_ff, pbs2_ff, pbc2_ff, pas2_ff;
   logic signed [TW-1:0]    tre3_ff, tim3_ff;
   logic signed [ACC_W-1:0] acc_re_ff, acc_re_in, acc_im_ff, acc_im_in;
   logic signed [ACC_W-1:0] sum_re, sum_im;
   logic signed [ACC_W-1:0] r5_re_ff, r5_im_ff;
   logic signed [ACC_W-1:0] t6_re_ff, t6_re_in, t6_im_ff, t6_im_in;
   logic                    rsp_valid_ff;
   logic signed [OUT_W-1:0] rsp_re_ff, rsp_im_ff;
   logic                    rsp_last_ff;

   // Pipeline and sample stepping move only when the result register can take a beat
   assign advance = !rsp_valid_ff || !rsp_stall;

   // Step through samples (inner) and bins (outer)
   always_comb begin
      state_in     = state_ff;
      bank_in      = bank_ff;
      l_in         = l_ff;
      inv_in       = inv_ff;
      nm1_in       = nm1_ff;
      step_in      = step_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      ph_in        = ph_ff;
      kstep_in     = kstep_ff;
      job_pop      = 1'b0;
      bank_release = 1'b0;
      issue        = 1'b0;
      case (state_ff)
         SEQ_IDLE: begin
            if (job_valid) begin
               job_pop  = 1'b1;
               bank_in  = job_head.bank;
               l_in     = job_head.l;
               inv_in   = job_head.inv;
               nm1_in   = AW'(((AW+1)'(1) << job_head.l) - (AW+1)'(1));
               step_in  = PHASE_W'(7'(ROM_TURN) >> job_head.l);
               j_in     = '0;
               k_in     = '0;
               ph_in    = '0;
               kstep_in = '0;
               state_in = SEQ_RUN;
            end
         end
         SEQ_RUN: begin
            if (advance) begin
               issue = 1'b1;
               if (j_ff == nm1_ff) begin
                  j_in     = '0;
                  ph_in    = '0;
                  k_in     = k_ff + AW'(1);
                  kstep_in = kstep_ff + step_ff;
                  if (k_ff == nm1_ff) begin
                     bank_release = 1'b1;
                     state_in     = SEQ_IDLE;
                  end
               end else begin
                  j_in  = j_ff + AW'(1);
                  ph_in = ph_ff + kstep_ff;
               end
            end
         end
         default: begin
            state_in = SEQ_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_IDLE;
      end else begin
         state_ff <= state_in;
      end
      bank_ff  <= bank_in;
      l_ff     <= l_in;
      inv_ff   <= inv_in;
      nm1_ff   <= nm1_in;
      step_ff  <= step_in;
      j_ff     <= j_in;
      k_ff     <= k_in;
      ph_ff    <= ph_in;
      kstep_ff <= kstep_in;
   end

   // Sample read goes out with the twiddle lookup
   assign rd_en   = advance;
   assign rd_addr = {bank_ff, j_ff};

   assign cos_w  = cos_at(ph_ff, TWIDDLE_BITS);
   assign sin_w  = sin_at(ph_ff, TWIDDLE_BITS);
   assign c1_in  = TB'(cos_w);
   assign sn1_in = inv_ff ? TB'(-sin_w) : TB'(sin_w);

   always_comb begin
      f1_in.valid     = issue;
      f1_in.first     = (j_ff == '0);
      f1_in.last_term = (j_ff == nm1_ff);
      f1_in.last_bin  = (k_ff == nm1_ff);
      f1_in.inv       = inv_ff;
      f1_in.l         = l_ff;
   end

   // Only the last term of a bin moves on past the accumulator
   always_comb begin
      f4_in       = f3_ff;
      f4_in.valid = f3_ff.valid && f3_ff.last_term;
   end

   // Accumulate the complex terms of one bin
   always_comb begin
      acc_re_in = acc_re_ff;
      acc_im_in = acc_im_ff;
      if (f3_ff.valid) begin
         acc_re_in = f3_ff.first ? ACC_W'(tre3_ff) : acc_re_ff + ACC_W'(tre3_ff);
         acc_im_in = f3_ff.first ? ACC_W'(tim3_ff) : acc_im_ff + ACC_W'(tim3_ff);
      end
   end

   // Round to the sample scale, floor
   assign sum_re = acc_re_ff + HALF;
   assign sum_im = acc_im_ff + HALF;

   // Inverse scaling by the length
   assign t6_re_in = f5_ff.inv ? trunc_shift(r5_re_ff, f5_ff.l) : r5_re_ff;
   assign t6_im_in = f5_ff.inv ? trunc_shift(r5_im_ff, f5_ff.l) : r5_im_ff;

   // Stage flags: control, cleared at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         f1_ff        <= '0;
         f2_ff        <= '0;
         f3_ff        <= '0;
         f4_ff        <= '0;
         f5_ff        <= '0;
         f6_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         f1_ff        <= f1_in;
         f2_ff        <= f1_ff;
         f3_ff        <= f2_ff;
         f4_ff        <= f4_in;
         f5_ff        <= f4_ff;
         f6_ff        <= f5_ff;
         rsp_valid_ff <= f6_ff.valid;
      end
   end

   // Stage data
   always_ff @(posedge clock) begin
      if (advance) begin
         c1_ff     <= c1_in;
         sn1_ff    <= sn1_in;
         pac2_ff   <= PW'(rd_re) * PW'(c1_ff);
         pbs2_ff   <= PW'(rd_im) * PW'(sn1_ff);
         pbc2_ff   <= PW'(rd_im) * PW'(c1_ff);
         pas2_ff   <= PW'(rd_re) * PW'(sn1_ff);
         tre3_ff   <= TW'(pac2_ff) + TW'(pbs2_ff);
         tim3_ff   <= TW'(pbc2_ff) - TW'(pas2_ff);
         acc_re_ff <= acc_re_in;
         acc_im_ff <= acc_im_in;
         r5_re_ff  <= sum_re >>> (TWIDDLE_BITS - 1);
         r5_im_ff  <= sum_im >>> (TWIDDLE_BITS - 1);
         t6_re_ff  <= t6_re_in;
         t6_im_ff  <= t6_im_in;
         if (f6_ff.valid) begin
            rsp_re_ff   <= saturate(t6_re_ff);
            rsp_im_ff   <= saturate(t6_im_ff);
            rsp_last_ff <= f6_ff.last_bin;
         end
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_bin_re   = rsp_re_ff;
   assign rsp_bin_im   = rsp_im_ff;
   assign rsp_bin_last = rsp_last_ff;

endmodule

`default_nettype wire

FILE: rtl/dft_1d_direct.sv
// ----------------------------------------------------------------------------
// dft_1d_direct
// Direct complex DFT of 2 to 64 points with a single shared complex MAC.
//
// Samples arrive one per beat on the req_ channel (valid/stall). After the
// last sample of a frame of N = 2^log2_points, N bins leave in order on the
// rsp_ channel, bin_last marking bin N-1. inverse_mode selects the inverse
// transform with division by N; it is taken when the last sample arrives.
// Writing log2_points drops any partly filled frame.
// Two sample banks are kept: one frame fills while the previous one is
// transformed. req_stall rises only when both banks are held by frames
// still waiting for or in the engine.
// The engine does one complex multiply-accumulate per cycle while rsp_ is
// not stalled. The first bin is offered after the queue hand-off, the N
// terms of bin 0, the pipeline stages (read and twiddle, products, term
// sum, accumulator, rounding, inverse scaling) and the output register.
// A stall on rsp_ freezes the engine; the front end keeps taking samples
// into the free bank. Reset clears the control state and restores
// log2_points to 6 and forward mode; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module dft_1d_direct
   import dftd_pkg::*;
#(
   parameter int MAX_POINTS   = DEF_MAX_POINTS,
   parameter int SAMPLE_BITS  = DEF_SAMPLE_BITS,
   parameter int TWIDDLE_BITS = DEF_TWIDDLE_BITS
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0]          csr_index,
   input  wire logic [CSR_DATA_W-1:0]         csr_wdata,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic signed [SAMPLE_BITS-1:0] req_sample_re,
   input  wire logic signed [SAMPLE_BITS-1:0] req_sample_im,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic signed [OUT_W-1:0]            rsp_bin_re,
   output logic signed [OUT_W-1:0]            rsp_bin_im,
   output logic                               rsp_bin_last
);

   localparam int AW = $clog2(MAX_POINTS);

   logic                          job_push;
   job_type                       job_new;
   logic                          job_pop;
   logic                          job_valid;
   job_type                       job_head;
   logic                          bank_release;
   logic                          rd_en;
   logic [AW:0]                   rd_addr;
   logic signed [SAMPLE_BITS-1:0] rd_re, rd_im;

   // Sample intake and banks
   dftd_front #(
      .MAX_POINTS  (MAX_POINTS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_sample_re    (req_sample_re),
      .req_sample_im    (req_sample_im),
      .job_push         (job_push),
      .job_out          (job_new),
      .bank_release     (bank_release),
      .rd_en            (rd_en),
      .rd_addr          (rd_addr),
      .rd_re            (rd_re),
      .rd_im            (rd_im)
   );

   // Frame hand-off
   dftd_job_fifo u_job_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_job  (job_new),
      .pop       (job_pop),
      .job_valid (job_valid),
      .job_head  (job_head)
   );

   // Transform engine
   dftd_back #(
      .MAX_POINTS   (MAX_POINTS),
      .SAMPLE_BITS  (SAMPLE_BITS),
      .TWIDDLE_BITS (TWIDDLE_BITS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .job_valid    (job_valid),
      .job_head     (job_head),
      .job_pop      (job_pop),
      .bank_release (bank_release),
      .rd_en        (rd_en),
      .rd_addr      (rd_addr),
      .rd_re        (rd_re),
      .rd_im        (rd_im),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_bin_re   (rsp_bin_re),
      .rsp_bin_im   (rsp_bin_im),
      .rsp_bin_last (rsp_bin_last)
   );

endmodule

`default_nettype wire

FILE: rtl/dftd_checker.sv
// ----------------------------------------------------------------------------
// dftd_checker
// Port-level checks for the direct DFT block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module dftd_checker
   import dftd_pkg::*;
(
   input wire logic                    clock,
   input wire logic                    reset,
   input wire logic                    req_valid,
   input wire logic                    req_stall,
   input wire logic                    rsp_valid,
   input wire logic                    rsp_stall,
   input wire logic signed [OUT_W-1:0] rsp_bin_re,
   input wire logic signed [OUT_W-1:0] rsp_bin_im,
   input wire logic                    rsp_bin_last
);

   // A waiting result beat stays offered
   a_rsp_valid_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp_valid dropped while stalled");

   // A waiting result beat keeps its payload
   a_rsp_payload_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_bin_re) && $stable(rsp_bin_im)
                                 && $stable(rsp_bin_last))
      else $error("rsp payload changed while stalled");

   // Reset empties the engine and frees both banks
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("block not idle after reset");

   // Banks fill up only through an accepted sample completing a frame
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(req_stall) |-> $past(req_valid && !req_stall))
      else $error("req_stall rose without an accepted sample");

endmodule

bind dft_1d_direct dftd_checker u_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_stall    (req_stall),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_bin_re   (rsp_bin_re),
   .rsp_bin_im   (rsp_bin_im),
   .rsp_bin_last (rsp_bin_last)
);

`default_nettype wire

FILE: tb/dft_1d_direct_test.sv
// ----------------------------------------------------------------------------
// dft_1d_direct_test
// Self-checking bench for the direct DFT block. A table of directed beats
// runs first: zero frames, impulse frames, full-scale samples, both
// directions, lengths out of range, and length or mode changed inside a
// frame. Randomised frames follow at lengths 2 to 64. Bins are compared
// with an in-bench fixed-point model of the transform, or with fixed values
// on marked directed frames. Both channels idle at random, and one long
// output hold backs the block up until it stalls its input.
// ----------------------------------------------------------------------------

module dft_1d_direct_test;
   import dftd_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int SAMPLE_W     = DEF_SAMPLE_BITS;
   localparam int RANDOM_ITEMS = 400;
   localparam int SETTLE       = 80;
   localparam int END_SETTLE   = 200;
   localparam int LONG_HOLD    = 600;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int NUM_ROWS     = 33;

   typedef struct packed {
      logic signed [OUT_W-1:0] re;
      logic signed [OUT_W-1:0] im;
      logic                    last;
   } bin_type;

   typedef enum logic [1:0] {ROW_LENGTH, ROW_MODE, ROW_SAMPLE} row_kind_type;

   // One directed step; fixed marks the last beat of a frame whose bins all
   // equal (fix_re, fix_im)
   typedef struct packed {
      row_kind_type               kind;
      logic [CSR_DATA_W-1:0]      setting;
      logic signed [SAMPLE_W-1:0] re;
      logic signed [SAMPLE_W-1:0] im;
      logic                       fixed;
      logic signed [OUT_W-1:0]    fix_re;
      logic signed [OUT_W-1:0]    fix_im;
   } step_row_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0]       csr_index = '0;
   logic [CSR_DATA_W-1:0]      csr_wdata = '0;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic signed [SAMPLE_W-1:0] req_sample_re = '0;
   logic signed [SAMPLE_W-1:0] req_sample_im = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic signed [OUT_W-1:0]    rsp_bin_re;
   logic signed [OUT_W-1:0]    rsp_bin_im;
   logic                       rsp_bin_last;

   // Transform model state
   logic [LOG2_W-1:0]          cfg_log2 = LOG2_RESET;
   logic                       cfg_inv = 1'b0;
   logic signed [SAMPLE_W-1:0] store_re [0:63];
   logic signed [SAMPLE_W-1:0] store_im [0:63];
   int                         fill_count = 0;
   bin_type                    frame_bins [0:63];
   bin_type                    bin_q [$];

   // Bookkeeping
   int           cycle_count = 0;
   int           fault_count = 0;
   int           samples_sent = 0;
   int           bins_checked = 0;
   int           frames_done = 0;
   int           settings_used = 0;
   int           holds_done = 0;
   bit           send_idle = 1'b1;
   bit           hold_wanted = 1'b0;
   step_row_type directed_rows [0:NUM_ROWS-1];

   dft_1d_direct dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_sample_re    (req_sample_re),
      .req_sample_im    (req_sample_im),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_bin_re       (rsp_bin_re),
      .rsp_bin_im       (rsp_bin_im),
      .rsp_bin_last     (rsp_bin_last)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d bins outstanding", cycle_count,
                  bin_q.size());
         $display("dft_1d_direct test failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Fixed-point transform model
   // ---------------------------------------------------------------------

   // Length code to log2 of the length actually used
   function automatic int active_log2(input logic [LOG2_W-1:0] code);
      if (code == 0) return 1;
      if (code > LOG2_LIMIT) return LOG2_LIMIT;
      return code;
   endfunction

   // Quarter-wave cosine in Q1.23, rounded half up to Q1.15 and capped
   function automatic longint twiddle_mag(input int r);
      longint v;
      case (r)
         0:  v = 8388608;
         1:  v = 8348215;
         2:  v = 8227423;
         3:  v = 8027397;
         4:  v = 7750063;
         5:  v = 7398092;
         6:  v = 6974873;
         7:  v = 6484482;
         8:  v = 5931642;
         9:  v = 5321677;
         10: v = 4660461;
         11: v = 3954362;
         12: v = 3210181;
         13: v = 2435084;
         14: v = 1636536;
         15: v = 822227;
         default: v = 0;
      endcase
      v = (v + 128) >>> 8;
      if (v > 32767) v = 32767;
      return v;
   endfunction

   // Cosine of a phase in 64ths of a turn, folded by quadrant
   function automatic longint cos_turn(input logic [5:0] p);
      logic [1:0] q;
      logic [3:0] r;
      longint     m;
      q = p[5:4];
      r = p[3:0];
      m = q[0] ? twiddle_mag(16 - r) : twiddle_mag(r);
      return (q == 2'd1 || q == 2'd2) ? -m : m;
   endfunction

   // Round the exact sum to sample scale, divide in inverse mode, saturate
   function automatic logic signed [OUT_W-1:0] scale_sum(input longint acc, input int l,
                                                         input bit inv);
      longint v;
      v = (acc + 16384) >>> 15;
      if (inv) v = (v < 0) ? -((-v) >>> l) : (v >>> l);
      if (v > OUT_MAX) v = OUT_MAX;
      if (v < OUT_MIN) v = OUT_MIN;
      return v[OUT_W-1:0];
   endfunction

   // Store one sample; on the last of a frame, fill frame_bins
   task automatic dft_take(input logic signed [SAMPLE_W-1:0] re, im, output int count);
      int          l;
      int          n;
      longint      acc_re;
      longint      acc_im;
      longint      c;
      longint      s;
      longint      a;
      longint      b;
      logic [5:0]  p;
      l = active_log2(cfg_log2);
      n = 1 << l;
      count = 0;
      if (fill_count >= n) fill_count = 0;
      store_re[fill_count] = re;
      store_im[fill_count] = im;
      fill_count++;
      if (fill_count < n) return;
      fill_count = 0;
      for (int k = 0; k < n; k++) begin
         acc_re = 0;
         acc_im = 0;
         for (int j = 0; j < n; j++) begin
            p = 6'(j * k * (ROM_TURN >> l));
            c = cos_turn(p);
            s = cos_turn(p + 6'd48);
            if (cfg_inv) s = -s;
            a = store_re[j];
            b = store_im[j];
            acc_re += a * c + b * s;
            acc_im += b * c - a * s;
         end
         frame_bins[k].re   = scale_sum(acc_re, l, cfg_inv);
         frame_bins[k].im   = scale_sum(acc_im, l, cfg_inv);
         frame_bins[k].last = (k == n - 1);
      end
      count = n;
      frames_done++;
   endtask

   // ---------------------------------------------------------------------
   // Drivers
   // ---------------------------------------------------------------------

   task automatic report_fault(input string what);
      fault_count++;
      if (fault_count <= 10) $display("ERROR cycle %0d: %s", cycle_count, what);
   endtask

   // Write a register once all due bins are out and the engine has drained
   task automatic set_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      req_valid <= 1'b0;
      while (bin_q.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_wdata        <= val;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      if (idx == REG_LOG2_POINTS) begin
         cfg_log2   = val;
         fill_count = 0;
      end else if (idx == REG_INVERSE_MODE) begin
         cfg_inv = val[0];
      end
      settings_used++;
   endtask

   // Offer one sample beat, then queue whatever bins it completes
   task automatic offer_sample(input logic signed [SAMPLE_W-1:0] re, im, input logic fixed,
                               input logic signed [OUT_W-1:0] fix_re, fix_im);
      int      gap;
      int      count;
      bin_type b;
      gap = send_idle ? $urandom_range(0, 15) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_sample_re <= re;
      req_sample_im <= im;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      dft_take(re, im, count);
      for (int k = 0; k < count; k++) begin
         b = frame_bins[k];
         if (fixed) begin
            b.re = fix_re;
            b.im = fix_im;
         end
         bin_q.push_back(b);
      end
      samples_sent++;
      @(negedge clock);
   endtask

   // Mostly uniform, sometimes full scale or near zero
   function automatic logic signed [SAMPLE_W-1:0] pick_value();
      case ($urandom_range(0, 7))
         0: return 16'sh7FFF;
         1: return 16'sh8000;
         2: return 16'(int'($urandom_range(0, 4)) - 2);
         default: return 16'($urandom);
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   initial begin : stimulus
      int                    phase;
      int                    frames;
      int                    points;
      bit                    pressure;
      logic [LOG2_W-1:0]     len_code;
      step_row_type          row;

      directed_rows = '{
         '{ROW_LENGTH, 3'd1, 16'sd0,      16'sd0,      1'b0, 24'sd0,     24'sd0},
         '{ROW_MODE,   3'd0, 16'sd0,      16'sd0,      1'b0, 24'sd0,     24'sd0},
         // all-zero frame
         '{ROW_SAMPLE, 3'd0, 16'sd0,      16'sd0,      1'b0, 24'sd0,     24'sd0},
         '{ROW_SAMPLE, 3'd0, 16'sd0,      16'sd0,      1'b1, 24'sd0,     24'sd0},
         // one LSB in the first sample only: every bin carries it
         '{ROW_SAMPLE, 3'd0, 16'sd1,      16'sd0,      1'b0, 24'sd0,     24'sd0},
         '{ROW_SAMPLE, 3'd0, 16'sd0,      16'sd0,      1'b1, 24'sd1,     24'sd0},
         '{ROW_SAMPLE, 3'd0, -16'sd1,     16'sd0,      1'b0, 24'sd0,     24'sd0},
         '{ROW_SAMPLE, 3'd0, 16'sd0,      16'sd0,      1'b1, -24'sd1,    24'sd0},
         '{ROW_SAMPLE, 3'd0, 16'sh7FFF,   16'sh8000,   1'b0, 24'sd0,     24'sd0},
         '{ROW_SAMPLE, 3'd0, 16'sd0,      16'sd0,      1'b1, 24'sd32766, -24'sd32767},
         '{ROW_SAMPLE, 3'd0, 16'sh7FFF,   16'sh7FFF,   1'b0, 24'sd0,     24'sd0},
         '{ROW_SAMPLE, 3'd0, 16'sh8000,   16'sh8000,   1'b0, 24'sd0,     24'sd0},
         // inverse: the divide truncates toward zero
         '{ROW_MODE,   3'd1, 16'sd0,      16'sd0,      1'b0, 24'sd0,     24'sd0},
         '{ROW_SAMPLE, 3'd0, 16'sd1,      16'sd0,      1'b0, 24'sd0,     24'sd0},
         '{ROW_SAMPLE, 3'd0, 16'sd0,      16'sd0,      1'b1, 24'sd0,     24'sd0},
         '{ROW_SAMPLE, 3'd0, -16'sd1,     16'sd0,      1'b0, 24'sd0,     24'sd0},
         '{ROW_SAMPLE, 3'd0, 16'sd0,      16'sd0,      1'b1, 24'sd0,     24'sd0},
         '{ROW_SAMPLE, 3'd0, 16'sh7FFF,   16'sh8000,   1'b0, 24'sd0,     24'sd0},
         '{ROW_SAMPLE, 3'd0, 16'sd0,      16'sd0,      1'b1, 24'sd16383, -24'sd16383},
         '{ROW_SAMPLE, 3'd0, 16'sh8000,   16'sh8000,   1'b0, 24'sd0,     24'sd0},
         '{ROW_SAMPLE, 3'd0, 16'sh8000,   16'sh8000,   1'b0, 24'sd0,     24'sd0},
         // zero length code behaves as two points
         '{ROW_LENGTH, 3'd0, 16'sd0,      16'sd0,      1'b0, 24'sd0,     24'sd0},
         '{ROW_MODE,   3'd0, 16'sd0,      16'sd0,      1'b0, 24'sd0,     24'sd0},
         '{ROW_SAMPLE, 3'd0, 16'sd12345,  -16'sd12345, 1'b0, 24'sd0,     24'sd0},
         '{ROW_SAMPLE, 3'd0, -16'sd1,     16'sd1,      1'b0, 24'sd0,     24'sd0},
         // length rewritten inside a frame drops the partial frame
         '{ROW_LENGTH, 3'd2, 16'sd0,      16'sd0,      1'b0, 24'sd0,     24'sd0},
         '{ROW_SAMPLE, 3'd0, 16'sh7FFF,   16'sh7FFF,   1'b0, 24'sd0,     24'sd0},
         '{ROW_LENGTH, 3'd1, 16'sd0,      16'sd0,      1'b0, 24'sd0,     24'sd0},
         '{ROW_SAMPLE, 3'd0, 16'sh8000,   16'sd0,      1'b0, 24'sd0,     24'sd0},
         '{ROW_SAMPLE, 3'd0, 16'sd0,      16'sh8000,   1'b0, 24'sd0,     24'sd0},
         // mode rewritten inside a frame takes effect on its last beat
         '{ROW_SAMPLE, 3'd0, 16'sd100,    -16'sd200,   1'b0, 24'sd0,     24'sd0},
         '{ROW_MODE,   3'd1, 16'sd0,      16'sd0,      1'b0, 24'sd0,     24'sd0},
         '{ROW_SAMPLE, 3'd0, -16'sd300,   16'sd400,    1'b0, 24'sd0,     24'sd0}
      };

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Walk the directed table
      for (int i = 0; i < NUM_ROWS; i++) begin
         row = directed_rows[i];
         case (row.kind)
            ROW_LENGTH: set_reg(REG_LOG2_POINTS, row.setting);
            ROW_MODE:   set_reg(REG_INVERSE_MODE, row.setting);
            default:    offer_sample(row.re, row.im, row.fixed, row.fix_re, row.fix_im);
         endcase
      end

      // Random frames: mostly short lengths, full length twice, one backed-up phase
      phase = 0;
      while (samples_sent < NUM_ROWS + RANDOM_ITEMS) begin
         frames   = $urandom_range(1, 4);
         len_code = LOG2_W'($urandom_range(0, 5));
         pressure = (phase == 2);
         if (phase == 1) begin
            len_code = LOG2_RESET;
            frames   = 1;
         end else if (phase == 4) begin
            len_code = 3'd7;
            frames   = 1;
         end else if (pressure) begin
            len_code = 3'd2;
            frames   = 8;
         end
         send_idle = !pressure && ($urandom_range(0, 3) != 0);
         set_reg(REG_LOG2_POINTS, len_code);
         set_reg(REG_INVERSE_MODE, {2'($urandom_range(0, 3)), 1'($urandom_range(0, 1))});
         if (pressure) hold_wanted = 1'b1;
         points = 1 << active_log2(len_code);
         repeat (frames * points) offer_sample(pick_value(), pick_value(), 1'b0, '0, '0);
         // leave a broken frame now and then; the next length write drops it
         if (!pressure && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, points - 1))
               offer_sample(pick_value(), pick_value(), 1'b0, '0, '0);
         phase++;
      end

      // Drain and look for stray bins
      req_valid <= 1'b0;
      while (bin_q.size() != 0) @(negedge clock);
      repeat (END_SETTLE) @(negedge clock);

      $display("Covered %0d sample beats, %0d frames and %0d bins over %0d register writes,",
               samples_sent, frames_done, bins_checked, settings_used);
      $display("lengths 2 to 64 in both directions, with %0d long output hold(s).",
               holds_done);
      if (fault_count == 0) begin
         $display("dft_1d_direct test passed");
      end else begin
         $display("%0d fault(s) seen", fault_count);
         $display("dft_1d_direct test failed");
      end
      $finish;
   end

   // ---------------------------------------------------------------------
   // Result side: random stall, one long hold on request
   // ---------------------------------------------------------------------
   initial begin : drain
      int gap;
      int served;
      bit idle_on;
      served  = 0;
      idle_on = 1'b1;
      while (reset) @(negedge clock);
      @(negedge clock);
      forever begin
         if (served % 40 == 0) idle_on = ($urandom_range(0, 3) != 0);
         gap = idle_on ? $urandom_range(0, 15) : 0;
         if (hold_wanted) begin
            gap += LONG_HOLD;
            hold_wanted = 1'b0;
            holds_done++;
         end
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(negedge clock);
            rsp_stall <= 1'b0;
         end
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         served++;
         @(negedge clock);
      end
   end

   // Compare each accepted bin with the oldest one due
   always @(posedge clock) begin
      bin_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         bins_checked++;
         if (bin_q.size() == 0) begin
            report_fault($sformatf("unexpected bin re=%0d im=%0d last=%0b",
                                   rsp_bin_re, rsp_bin_im, rsp_bin_last));
         end else begin
            want = bin_q.pop_front();
            if (rsp_bin_re !== want.re)
               report_fault($sformatf("bin %0d re: expected %0d, got %0d",
                                      bins_checked, want.re, rsp_bin_re));
            if (rsp_bin_im !== want.im)
               report_fault($sformatf("bin %0d im: expected %0d, got %0d",
                                      bins_checked, want.im, rsp_bin_im));
            if (rsp_bin_last !== want.last)
               report_fault($sformatf("bin %0d last: expected %0b, got %0b",
                                      bins_checked, want.last, rsp_bin_last));
         end
      end
   end

endmodule
